// ===== src/grs_pkg.sv =====
// Shared types and constants for the gamepad button repeat scaler.
package grs_pkg;

    localparam int PORT_W    = 2;
    localparam int STICK_W   = 8;
    localparam int BTN_W     = 16;
    localparam int SCALED_W  = 18;
    localparam int TIMER_W   = 10;
    localparam int CFG_W     = 8;
    localparam int CFG_IDX_W = 3;
    localparam int GAIN_A_W  = 10;
    localparam int GAIN_R_W  = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_X        = 3'd0,
        CFG_GAIN_Y        = 3'd1,
        CFG_INITIAL_DELAY = 3'd2,
        CFG_REPEAT_DELAY  = 3'd3,
        CFG_TICK_STEP     = 3'd4
    } cfg_idx_t;

    localparam int GAIN_RESET          = 70;
    localparam int INITIAL_DELAY_RESET = 10;
    localparam int REPEAT_DELAY_RESET  = 5;
    localparam int TICK_STEP_RESET     = 1;

    // gain * 16 = 5 * a + r, so stick * gain * 16 / 5 = stick * a + stick * r / 5
    localparam int GAIN_A_RESET = (GAIN_RESET * 16) / 5;
    localparam int GAIN_R_RESET = (GAIN_RESET * 16) % 5;

    typedef struct packed {
        logic [GAIN_A_W-1:0] a;
        logic [GAIN_R_W-1:0] r;
    } gain_split_t;

endpackage

// ===== src/grs_ifs.sv =====
// Request, result and configuration channel interfaces.
interface grs_poll_if import grs_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [PORT_W-1:0]         port;
    logic                      read_error;
    logic signed [STICK_W-1:0] stick_x;
    logic signed [STICK_W-1:0] stick_y;
    logic [BTN_W-1:0]          buttons;

    modport source(output valid, port, read_error, stick_x, stick_y, buttons, input ready);
    modport sink(input valid, port, read_error, stick_x, stick_y, buttons, output ready);
endinterface

interface grs_result_if import grs_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic                       connected;
    logic signed [SCALED_W-1:0] scaled_x;
    logic signed [SCALED_W-1:0] scaled_y;
    logic [BTN_W-1:0]           held_buttons;
    logic [BTN_W-1:0]           pressed_edges;
    logic [BTN_W-1:0]           repeat_buttons;

    modport source(output valid, connected, scaled_x, scaled_y, held_buttons,
                   pressed_edges, repeat_buttons, input ready);
    modport sink(input valid, connected, scaled_x, scaled_y, held_buttons,
                 pressed_edges, repeat_buttons, output ready);
endinterface

interface grs_cfg_if import grs_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;

    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

// ===== src/gamepad_button_repeat_scaler.sv =====
// Gamepad poll processor: per-port edge detect, auto-repeat and stick scaling.
//
// One poll request in, one result out. A request is accepted every cycle as long
// as the result side keeps up; its result passes through the input register and
// then the result register. The rate is set by the per-port state
// read-modify-write, which completes between the two registers, so back-to-back
// polls of the same port see each other's updates. Configuration writes are
// always accepted and must only occur while idle. Polls of a port number at or
// above NUM_PORTS leave state untouched and give an all-zero result.
module gamepad_button_repeat_scaler import grs_pkg::*; #(
    parameter int NUM_PORTS = 4
) (
    input  logic         clk,
    input  logic         rst_n,
    grs_poll_if.sink     poll,
    grs_result_if.source result,
    grs_cfg_if.sink      cfg
);

    localparam int PIDX_W = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;

    function automatic gain_split_t split_gain(input logic [CFG_W-1:0] g);
        logic [11:0]   x16;
        logic [23:0]   prod;
        logic [11:0]   rem;
        gain_split_t   res;
        x16   = {g, 4'b0000};
        prod  = 24'(x16) * 24'd3277;
        res.a = prod[23:14];
        rem   = x16 - ({2'b00, res.a} * 12'd5);
        res.r = rem[GAIN_R_W-1:0];
        return res;
    endfunction

    // trunc(s * gain * 16 / 5) in Q.8
    function automatic logic [SCALED_W-1:0] scale_axis(
        input logic signed [STICK_W-1:0] s,
        input gain_split_t               gs
    );
        logic [STICK_W-1:0]  mag;
        logic [SCALED_W-1:0] main;
        logic [9:0]          small_p;
        logic [17:0]         recip;
        logic [SCALED_W-1:0] sum;
        mag  = s[STICK_W-1] ? STICK_W'(-s) : STICK_W'(s);
        main = SCALED_W'(mag) * SCALED_W'(gs.a);
        case (gs.r)
            3'd1:    small_p = {2'b00, mag};
            3'd2:    small_p = {1'b0, mag, 1'b0};
            3'd3:    small_p = {1'b0, mag, 1'b0} + {2'b00, mag};
            3'd4:    small_p = {mag, 2'b00};
            default: small_p = '0;
        endcase
        recip = 18'(small_p) * 18'd205;
        sum   = main + SCALED_W'(recip[17:10]);
        return s[STICK_W-1] ? SCALED_W'(-sum) : sum;
    endfunction

    // configuration
    gain_split_t      gain_x_reg;
    gain_split_t      gain_y_reg;
    logic [CFG_W-1:0] initial_delay_reg;
    logic [CFG_W-1:0] repeat_delay_reg;
    logic [CFG_W-1:0] tick_step_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_x_reg        <= '{a: GAIN_A_W'(GAIN_A_RESET), r: GAIN_R_W'(GAIN_R_RESET)};
            gain_y_reg        <= '{a: GAIN_A_W'(GAIN_A_RESET), r: GAIN_R_W'(GAIN_R_RESET)};
            initial_delay_reg <= CFG_W'(INITIAL_DELAY_RESET);
            repeat_delay_reg  <= CFG_W'(REPEAT_DELAY_RESET);
            tick_step_reg     <= CFG_W'(TICK_STEP_RESET);
        end
        else if (cfg.valid)
        begin
            unique case (cfg_idx_t'(cfg.index))
                CFG_GAIN_X:        gain_x_reg        <= split_gain(cfg.data);
                CFG_GAIN_Y:        gain_y_reg        <= split_gain(cfg.data);
                CFG_INITIAL_DELAY: initial_delay_reg <= cfg.data;
                CFG_REPEAT_DELAY:  repeat_delay_reg  <= cfg.data;
                CFG_TICK_STEP:     tick_step_reg     <= cfg.data;
                default:           ;
            endcase
        end
    end

    // handshake
    logic s1_valid_reg;
    logic out_valid_reg;
    logic advance;
    logic poll_accept;

    assign advance     = s1_valid_reg && (!out_valid_reg || result.ready);
    assign poll.ready  = !s1_valid_reg || advance;
    assign poll_accept = poll.valid && poll.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (poll.ready)
                s1_valid_reg <= poll.valid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // input register
    logic [PORT_W-1:0]         s1_port_reg;
    logic                      s1_err_reg;
    logic signed [STICK_W-1:0] s1_sx_reg;
    logic signed [STICK_W-1:0] s1_sy_reg;
    logic [BTN_W-1:0]          s1_btn_reg;

    always_ff @(posedge clk)
    begin
        if (poll_accept)
        begin
            s1_port_reg <= poll.port;
            s1_err_reg  <= poll.read_error;
            s1_sx_reg   <= poll.stick_x;
            s1_sy_reg   <= poll.stick_y;
            s1_btn_reg  <= poll.buttons;
        end
    end

    // per-port state
    logic                      conn_reg  [NUM_PORTS];
    logic [BTN_W-1:0]          prev_reg  [NUM_PORTS];
    logic [BTN_W-1:0]          held_reg  [NUM_PORTS];
    logic signed [TIMER_W-1:0] timer_reg [NUM_PORTS];

    logic [PIDX_W-1:0]         s1_pidx;
    logic                      s1_in_range;
    logic [BTN_W-1:0]          prev_cur;
    logic [BTN_W-1:0]          held_cur;
    logic signed [TIMER_W-1:0] timer_cur;
    logic signed [TIMER_W-1:0] timer_dec;

    logic                      conn_next;
    logic [BTN_W-1:0]          prev_next;
    logic [BTN_W-1:0]          held_next;
    logic signed [TIMER_W-1:0] timer_next;

    logic                      connected_next;
    logic [SCALED_W-1:0]       scaled_x_next;
    logic [SCALED_W-1:0]       scaled_y_next;
    logic [BTN_W-1:0]          held_buttons_next;
    logic [BTN_W-1:0]          pressed_edges_next;
    logic [BTN_W-1:0]          repeat_buttons_next;

    assign s1_pidx     = PIDX_W'(s1_port_reg);
    assign s1_in_range = 32'(s1_port_reg) < NUM_PORTS;
    assign prev_cur    = prev_reg[s1_pidx];
    assign held_cur    = held_reg[s1_pidx];
    assign timer_cur   = timer_reg[s1_pidx];
    assign timer_dec   = timer_cur - TIMER_W'(tick_step_reg);

    always_comb
    begin
        conn_next           = 1'b0;
        prev_next           = '0;
        held_next           = '0;
        timer_next          = '0;
        connected_next      = 1'b0;
        scaled_x_next       = '0;
        scaled_y_next       = '0;
        held_buttons_next   = '0;
        pressed_edges_next  = '0;
        repeat_buttons_next = '0;
        if (s1_in_range && !s1_err_reg)
        begin
            conn_next          = 1'b1;
            prev_next          = s1_btn_reg;
            held_next          = held_cur;
            connected_next     = 1'b1;
            scaled_x_next      = scale_axis(s1_sx_reg, gain_x_reg);
            scaled_y_next      = scale_axis(s1_sy_reg, gain_y_reg);
            held_buttons_next  = s1_btn_reg;
            pressed_edges_next = s1_btn_reg & ~prev_cur;
            if (s1_btn_reg != held_cur)
            begin
                held_next           = s1_btn_reg;
                repeat_buttons_next = s1_btn_reg;
                timer_next          = TIMER_W'(initial_delay_reg);
            end
            else if (timer_dec < 0)
            begin
                repeat_buttons_next = held_cur;
                timer_next          = TIMER_W'(repeat_delay_reg);
            end
            else
            begin
                timer_next = timer_dec;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_PORTS; i++)
            begin
                conn_reg[i]  <= 1'b1;
                prev_reg[i]  <= '0;
                held_reg[i]  <= '0;
                timer_reg[i] <= '0;
            end
        end
        else if (advance && s1_in_range)
        begin
            conn_reg[s1_pidx]  <= conn_next;
            prev_reg[s1_pidx]  <= prev_next;
            held_reg[s1_pidx]  <= held_next;
            timer_reg[s1_pidx] <= timer_next;
        end
    end

    // result register
    logic                connected_reg;
    logic [SCALED_W-1:0] scaled_x_reg;
    logic [SCALED_W-1:0] scaled_y_reg;
    logic [BTN_W-1:0]    held_buttons_reg;
    logic [BTN_W-1:0]    pressed_edges_reg;
    logic [BTN_W-1:0]    repeat_buttons_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            connected_reg      <= connected_next;
            scaled_x_reg       <= scaled_x_next;
            scaled_y_reg       <= scaled_y_next;
            held_buttons_reg   <= held_buttons_next;
            pressed_edges_reg  <= pressed_edges_next;
            repeat_buttons_reg <= repeat_buttons_next;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.connected      = connected_reg;
    assign result.scaled_x       = scaled_x_reg;
    assign result.scaled_y       = scaled_y_reg;
    assign result.held_buttons   = held_buttons_reg;
    assign result.pressed_edges  = pressed_edges_reg;
    assign result.repeat_buttons = repeat_buttons_reg;

    // checks
    a_err_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && s1_err_reg) |=> (result.valid && !result.connected
            && result.held_buttons == '0 && result.repeat_buttons == '0))
        else $error("error poll did not give a cleared result");

    a_edges_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((pressed_edges_reg & ~held_buttons_reg) == '0))
        else $error("pressed edge outside held buttons");

    a_timer_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_in_range) |-> !timer_cur[TIMER_W-1])
        else $error("stored repeat timer negative");

    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        !poll.ready |-> (s1_valid_reg && out_valid_reg && !result.ready))
        else $error("request side stalled without a full pipeline");

    a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
        poll_accept |=> s1_valid_reg)
        else $error("accepted request lost");

endmodule
